// ===== rtl/slot_power_sequencer_assert.svh =====
// Assertion macros for the slot power sequencer
`ifndef SLOT_POWER_SEQUENCER_ASSERT_SVH
`define SLOT_POWER_SEQUENCER_ASSERT_SVH

// condition holds at every edge outside reset
`define SPS_ASSERT(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define SPS_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sps_pkg.sv =====
package sps_pkg;

    typedef struct packed {
        logic tick;
        logic module_present;
        logic fault;
        logic write_done;
    } in_t;

    typedef struct packed {
        logic        fuse_on;
        logic        send_request;
        logic [7:0]  send_address;
        logic [15:0] send_word;
        logic [2:0]  slot_state;
    } out_t;

    typedef struct packed {
        logic [15:0] start_delay;
        logic [15:0] plug_delay;
        logic [4:0]  limit_step;
        logic [7:0]  pot_address;
    } cfg_t;

    typedef struct packed {
        logic        load;
        logic [15:0] value;
    } start_load_t;

    typedef enum logic [6:0] {
        PH_START  = 7'b0000001,
        PH_UNLOCK = 7'b0000010,
        PH_IDLE   = 7'b0000100,
        PH_PLUG   = 7'b0001000,
        PH_LIMIT  = 7'b0010000,
        PH_ACTIVE = 7'b0100000,
        PH_TRIP   = 7'b1000000
    } phase_t;

    localparam logic [2:0] ST_START  = 3'd0;
    localparam logic [2:0] ST_UNLOCK = 3'd1;
    localparam logic [2:0] ST_IDLE   = 3'd2;
    localparam logic [2:0] ST_PLUG   = 3'd3;
    localparam logic [2:0] ST_LIMIT  = 3'd4;
    localparam logic [2:0] ST_ACTIVE = 3'd5;
    localparam logic [2:0] ST_TRIP   = 3'd6;

    localparam logic [7:0] CFG_START_DELAY = 8'd0;
    localparam logic [7:0] CFG_PLUG_DELAY  = 8'd1;
    localparam logic [7:0] CFG_LIMIT_STEP  = 8'd2;
    localparam logic [7:0] CFG_POT_ADDRESS = 8'd3;

    localparam logic [15:0] START_DELAY_RST = 16'd10;
    localparam logic [15:0] PLUG_DELAY_RST  = 16'd500;
    localparam logic [4:0]  LIMIT_STEP_RST  = 5'd20;
    localparam logic [7:0]  POT_ADDRESS_RST = 8'd88;

    localparam logic [15:0] UNLOCK_WORD = 16'h1C02;
    localparam logic [15:0] LIMIT_BASE  = 16'h0400;
    localparam logic [4:0]  LIMIT_TOP   = 5'd20;

    function automatic logic [15:0] ilim(input logic [4:0] step);
        logic [15:0] v;
        case (step)
            5'd0:    v = 16'd816;
            5'd1:    v = 16'd816;
            5'd2:    v = 16'd422;
            5'd3:    v = 16'd281;
            5'd4:    v = 16'd209;
            5'd5:    v = 16'd165;
            5'd6:    v = 16'd136;
            5'd7:    v = 16'd115;
            5'd8:    v = 16'd98;
            5'd9:    v = 16'd86;
            5'd10:   v = 16'd76;
            5'd11:   v = 16'd67;
            5'd12:   v = 16'd60;
            5'd13:   v = 16'd55;
            5'd14:   v = 16'd50;
            5'd15:   v = 16'd45;
            5'd16:   v = 16'd41;
            5'd17:   v = 16'd38;
            5'd18:   v = 16'd35;
            5'd19:   v = 16'd33;
            default: v = 16'd30;
        endcase
        return v;
    endfunction

    function automatic logic [2:0] state_code(input phase_t ph);
        logic [2:0] c;
        case (ph)
            PH_START:  c = ST_START;
            PH_UNLOCK: c = ST_UNLOCK;
            PH_PLUG:   c = ST_PLUG;
            PH_LIMIT:  c = ST_LIMIT;
            PH_ACTIVE: c = ST_ACTIVE;
            PH_TRIP:   c = ST_TRIP;
            default:   c = ST_IDLE;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/sps_cfg.sv =====
module sps_cfg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic [7:0]           cfg_index,
    input  logic [15:0]          cfg_data,
    output sps_pkg::cfg_t        cfg,
    output sps_pkg::start_load_t start_load
);

    sps_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_delay <= sps_pkg::START_DELAY_RST;
            cfg_reg.plug_delay  <= sps_pkg::PLUG_DELAY_RST;
            cfg_reg.limit_step  <= sps_pkg::LIMIT_STEP_RST;
            cfg_reg.pot_address <= sps_pkg::POT_ADDRESS_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                sps_pkg::CFG_START_DELAY: cfg_reg.start_delay <= cfg_data;
                sps_pkg::CFG_PLUG_DELAY:  cfg_reg.plug_delay  <= cfg_data;
                sps_pkg::CFG_LIMIT_STEP:  cfg_reg.limit_step  <= cfg_data[4:0];
                sps_pkg::CFG_POT_ADDRESS: cfg_reg.pot_address <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign cfg              = cfg_reg;
    assign start_load.load  = cfg_valid && (cfg_index == sps_pkg::CFG_START_DELAY);
    assign start_load.value = cfg_data;

endmodule

// ===== rtl/sps_fsm.sv =====
module sps_fsm (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 accept,
    input  sps_pkg::in_t         in_data,
    input  sps_pkg::cfg_t        cfg,
    input  sps_pkg::start_load_t start_load,
    output sps_pkg::out_t        result
);

    sps_pkg::phase_t phase_reg, phase_next;
    logic [15:0]     delay_count_reg, delay_count_next;
    logic [15:0]     count_step;
    logic            delay_end;
    logic            req;
    logic [15:0]     word;
    logic [4:0]      step_sat;
    logic [15:0]     limit_word;

    always_comb begin
        step_sat   = (cfg.limit_step > sps_pkg::LIMIT_TOP) ? sps_pkg::LIMIT_TOP : cfg.limit_step;
        limit_word = sps_pkg::LIMIT_BASE | sps_pkg::ilim(step_sat);
        delay_end  = (delay_count_reg == 16'd0) ||
                     (in_data.tick && (delay_count_reg == 16'd1));
        count_step = ((delay_count_reg != 16'd0) && in_data.tick) ?
                     (delay_count_reg - 16'd1) : delay_count_reg;

        phase_next       = phase_reg;
        delay_count_next = delay_count_reg;
        req              = 1'b0;
        word             = '0;

        case (phase_reg)
            sps_pkg::PH_START: begin
                delay_count_next = count_step;
                if (delay_end) begin
                    phase_next = sps_pkg::PH_UNLOCK;
                    req        = 1'b1;
                    word       = sps_pkg::UNLOCK_WORD;
                end
            end
            sps_pkg::PH_UNLOCK: begin
                if (in_data.write_done) phase_next = sps_pkg::PH_IDLE;
            end
            sps_pkg::PH_PLUG: begin
                if (!in_data.module_present) begin
                    phase_next = sps_pkg::PH_IDLE;
                end else begin
                    delay_count_next = count_step;
                    if (delay_end) begin
                        phase_next = sps_pkg::PH_LIMIT;
                        req        = 1'b1;
                        word       = limit_word;
                    end
                end
            end
            sps_pkg::PH_LIMIT: begin
                if (in_data.write_done) phase_next = sps_pkg::PH_ACTIVE;
            end
            sps_pkg::PH_ACTIVE: begin
                if (in_data.fault) phase_next = sps_pkg::PH_TRIP;
                else if (!in_data.module_present) phase_next = sps_pkg::PH_IDLE;
            end
            sps_pkg::PH_TRIP: begin
                if (!in_data.module_present) phase_next = sps_pkg::PH_IDLE;
            end
            default: begin
                phase_next = sps_pkg::PH_IDLE;
                if (in_data.module_present) begin
                    phase_next       = sps_pkg::PH_PLUG;
                    delay_count_next = cfg.plug_delay;
                    if (cfg.plug_delay == 16'd0) begin
                        phase_next = sps_pkg::PH_LIMIT;
                        req        = 1'b1;
                        word       = limit_word;
                    end
                end
            end
        endcase

        result.fuse_on      = (phase_next == sps_pkg::PH_ACTIVE);
        result.send_request = req;
        result.send_address = req ? cfg.pot_address : 8'd0;
        result.send_word    = word;
        result.slot_state   = sps_pkg::state_code(phase_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= sps_pkg::PH_START;
            delay_count_reg <= sps_pkg::START_DELAY_RST;
        end else if (accept) begin
            phase_reg       <= phase_next;
            delay_count_reg <= delay_count_next;
        end else if (start_load.load && (phase_reg == sps_pkg::PH_START)) begin
            delay_count_reg <= start_load.value;
        end
    end

endmodule

// ===== rtl/slot_power_sequencer.sv =====
// Power sequencer for one plug-in module slot; instantiate once per slot.
// Input channel (s_): one service sample per word (tick, module presence,
// eFuse fault, bus write completion). Result channel (m_): one word per
// sample with the fuse enable, a one-word bus write request (address and
// data) and the slot state code after that sample.
// Configuration channel (cfg_): register index and data; always ready. The
// user must see that it is written only while no sample is in flight; the
// block itself does not enforce this. The result of a sample is on m_ the
// cycle after it is accepted. Throughput: one sample per cycle while the
// receiver does not stall; the state machine decides each step in a single
// pass from the state registers to the result register. Receiver stall:
// the result register holds its word and s_ready drops until m_ready frees
// it; a new sample is taken in the cycle the held word leaves.
// Reset (aresetn low, synchronous): state goes to start with the start
// delay loaded, the registers return to their defaults and m_ is empty.
module slot_power_sequencer (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  sps_pkg::in_t   s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output sps_pkg::out_t  m_data,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [7:0]     cfg_index,
    input  logic [15:0]    cfg_data
);

`include "slot_power_sequencer_assert.svh"

    sps_pkg::cfg_t        cfg;
    sps_pkg::start_load_t start_load;
    sps_pkg::out_t        result;
    sps_pkg::out_t        m_data_reg;
    logic                 m_valid_reg;
    logic                 accept;

    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    sps_cfg u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cfg        (cfg),
        .start_load (start_load)
    );

    sps_fsm u_fsm (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .in_data    (s_data),
        .cfg        (cfg),
        .start_load (start_load),
        .result     (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `SPS_ASSERT_IMPL(a_req_state, aclk, aresetn, m_valid_reg && m_data_reg.send_request, (m_data_reg.slot_state == sps_pkg::ST_UNLOCK) || (m_data_reg.slot_state == sps_pkg::ST_LIMIT), "write request outside a write state")
    `SPS_ASSERT_IMPL(a_fuse_state, aclk, aresetn, m_valid_reg, m_data_reg.fuse_on == (m_data_reg.slot_state == sps_pkg::ST_ACTIVE), "fuse enable disagrees with state")
    `SPS_ASSERT_IMPL(a_idle_bus, aclk, aresetn, m_valid_reg && !m_data_reg.send_request, (m_data_reg.send_address == 8'd0) && (m_data_reg.send_word == 16'd0), "bus fields set without a request")

endmodule

// ===== bench/tb_slot_power_sequencer.sv =====
`timescale 1ns / 100ps

module tb_slot_power_sequencer;

    localparam int FLOW_FREE        = 0;
    localparam int FLOW_SEND_GAPS   = 1;
    localparam int FLOW_RECV_STALLS = 2;
    localparam int FLOW_BOTH        = 3;

    localparam logic [15:0] UNLOCK_DATA  = 16'h1C02;
    localparam logic [15:0] LIMIT_PREFIX = 16'h0400;
    localparam logic [4:0]  LIMIT_MAX    = 5'd20;
    localparam logic [15:0] CURRENT_CODES [21] = '{
        16'd816, 16'd816, 16'd422, 16'd281, 16'd209, 16'd165, 16'd136,
        16'd115, 16'd98, 16'd86, 16'd76, 16'd67, 16'd60, 16'd55,
        16'd50, 16'd45, 16'd41, 16'd38, 16'd35, 16'd33, 16'd30
    };

    logic          aclk      = 1'b0;
    logic          aresetn   = 1'b0;
    logic          s_valid   = 1'b0;
    logic          s_ready;
    sps_pkg::in_t  s_data    = '0;
    logic          m_valid;
    logic          m_ready   = 1'b0;
    sps_pkg::out_t m_data;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [7:0]    cfg_index = '0;
    logic [15:0]   cfg_data  = '0;

    logic [2:0]  slot_phase;
    logic [15:0] ticks_left;
    logic [15:0] start_delay_r;
    logic [15:0] plug_delay_r;
    logic [4:0]  limit_step_r;
    logic [7:0]  pot_address_r;

    sps_pkg::out_t pending_results[$];
    logic [7:0]    reg_index_q[$];
    logic [15:0]   reg_value_q[$];

    int flow_mode    = FLOW_FREE;
    int fail_count   = 0;
    int sample_count = 0;
    int result_count = 0;
    int write_count  = 0;
    int trip_count   = 0;

    always #5 aclk = ~aclk;

    slot_power_sequencer u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    function automatic logic tick_down(input logic tick);
        if (ticks_left == 16'd0) begin
            return 1'b1;
        end
        if (tick) begin
            ticks_left = ticks_left - 16'd1;
            return ticks_left == 16'd0;
        end
        return 1'b0;
    endfunction

    function automatic logic [15:0] limit_data();
        logic [4:0] k;
        k = (limit_step_r > LIMIT_MAX) ? LIMIT_MAX : limit_step_r;
        return LIMIT_PREFIX | CURRENT_CODES[k];
    endfunction

    function automatic sps_pkg::out_t next_slot_word(input sps_pkg::in_t d);
        sps_pkg::out_t r;
        logic          req;
        logic [15:0]   data;
        req  = 1'b0;
        data = '0;
        case (slot_phase)
            sps_pkg::ST_START: begin
                if (tick_down(d.tick)) begin
                    slot_phase = sps_pkg::ST_UNLOCK;
                    req        = 1'b1;
                    data       = UNLOCK_DATA;
                end
            end
            sps_pkg::ST_UNLOCK: begin
                if (d.write_done) begin
                    slot_phase = sps_pkg::ST_IDLE;
                end
            end
            sps_pkg::ST_PLUG: begin
                if (!d.module_present) begin
                    slot_phase = sps_pkg::ST_IDLE;
                end else if (tick_down(d.tick)) begin
                    slot_phase = sps_pkg::ST_LIMIT;
                    req        = 1'b1;
                    data       = limit_data();
                end
            end
            sps_pkg::ST_LIMIT: begin
                if (d.write_done) begin
                    slot_phase = sps_pkg::ST_ACTIVE;
                end
            end
            sps_pkg::ST_ACTIVE: begin
                if (d.fault) begin
                    slot_phase = sps_pkg::ST_TRIP;
                    trip_count++;
                end else if (!d.module_present) begin
                    slot_phase = sps_pkg::ST_IDLE;
                end
            end
            sps_pkg::ST_TRIP: begin
                if (!d.module_present) begin
                    slot_phase = sps_pkg::ST_IDLE;
                end
            end
            default: begin
                slot_phase = sps_pkg::ST_IDLE;
                if (d.module_present) begin
                    slot_phase = sps_pkg::ST_PLUG;
                    ticks_left = plug_delay_r;
                    if (ticks_left == 16'd0) begin
                        slot_phase = sps_pkg::ST_LIMIT;
                        req        = 1'b1;
                        data       = limit_data();
                    end
                end
            end
        endcase
        if (req) begin
            write_count++;
        end
        r.fuse_on      = (slot_phase == sps_pkg::ST_ACTIVE);
        r.send_request = req;
        r.send_address = req ? pot_address_r : 8'd0;
        r.send_word    = data;
        r.slot_state   = slot_phase;
        return r;
    endfunction

    function automatic void apply_reg(input logic [7:0] idx, input logic [15:0] val);
        case (idx)
            sps_pkg::CFG_START_DELAY: begin
                start_delay_r = val;
                if (slot_phase == sps_pkg::ST_START) begin
                    ticks_left = val;
                end
            end
            sps_pkg::CFG_PLUG_DELAY:  plug_delay_r  = val;
            sps_pkg::CFG_LIMIT_STEP:  limit_step_r  = val[4:0];
            sps_pkg::CFG_POT_ADDRESS: pot_address_r = val[7:0];
            default: ;
        endcase
    endfunction

    function automatic bit sender_waits();
        case (flow_mode)
            FLOW_SEND_GAPS: return $urandom_range(0, 99) < 76;
            FLOW_BOTH:      return $urandom_range(0, 99) < 9;
            default:        return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (flow_mode)
            FLOW_RECV_STALLS: return $urandom_range(0, 99) < 76;
            FLOW_BOTH:        return $urandom_range(0, 99) < 9;
            default:          return 1'b0;
        endcase
    endfunction

    task automatic send_sample(input sps_pkg::in_t d);
        while (sender_waits()) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= d;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        pending_results.push_back(next_slot_word(d));
        sample_count++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic put_reg(input logic [7:0] idx, input logic [15:0] val);
        reg_index_q.push_back(idx);
        reg_value_q.push_back(val);
    endtask

    task automatic flush_regs();
        while (reg_index_q.size() != 0) begin
            cfg_valid <= 1'b1;
            cfg_index <= reg_index_q[0];
            cfg_data  <= reg_value_q[0];
            @(posedge aclk);
            while (!cfg_ready) begin
                @(posedge aclk);
            end
            apply_reg(reg_index_q.pop_front(), reg_value_q.pop_front());
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic sps_pkg::in_t sample(input logic tick, input logic present,
                                            input logic fault, input logic done);
        sps_pkg::in_t d;
        d.tick           = tick;
        d.module_present = present;
        d.fault          = fault;
        d.write_done     = done;
        return d;
    endfunction

    // bias towards progress through the current state
    function automatic sps_pkg::in_t random_sample();
        sps_pkg::in_t d;
        d = sps_pkg::in_t'(4'($urandom_range(0, 15)));
        if ($urandom_range(0, 99) < 15) begin
            return d;
        end
        case (slot_phase)
            sps_pkg::ST_START:  d.tick = ($urandom_range(0, 9) < 8);
            sps_pkg::ST_UNLOCK: d.write_done = ($urandom_range(0, 2) == 0);
            sps_pkg::ST_PLUG: begin
                d.module_present = ($urandom_range(0, 19) != 0);
                d.tick           = ($urandom_range(0, 9) < 7);
            end
            sps_pkg::ST_LIMIT: begin
                d.write_done     = ($urandom_range(0, 2) == 0);
                d.module_present = ($urandom_range(0, 9) != 0);
            end
            sps_pkg::ST_ACTIVE: begin
                d.fault          = ($urandom_range(0, 9) == 0);
                d.module_present = ($urandom_range(0, 6) != 0);
            end
            sps_pkg::ST_TRIP:   d.module_present = ($urandom_range(0, 2) != 0);
            default:            d.module_present = 1'($urandom_range(0, 1));
        endcase
        return d;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        sps_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result word %h with nothing outstanding", m_data);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("fuse_on", 16'(want.fuse_on), 16'(m_data.fuse_on));
                check_field("send_request", 16'(want.send_request),
                            16'(m_data.send_request));
                check_field("send_address", 16'(want.send_address),
                            16'(m_data.send_address));
                check_field("send_word", want.send_word, m_data.send_word);
                check_field("slot_state", 16'(want.slot_state), 16'(m_data.slot_state));
                result_count++;
            end
        end
        m_ready <= aresetn && !receiver_stalls();
    end

    task automatic test_start_sequence();
        flow_mode = FLOW_BOTH;
        wait_drained();
        put_reg(sps_pkg::CFG_START_DELAY, 16'hFFFF);
        put_reg(sps_pkg::CFG_START_DELAY, 16'd3);
        flush_regs();
        send_sample(sample(1'b0, 1'b1, 1'b1, 1'b1));
        send_sample(sample(1'b1, 1'b0, 1'b0, 1'b0));
        wait_drained();
        put_reg(sps_pkg::CFG_START_DELAY, 16'd0);
        flush_regs();
        send_sample(sample(1'b0, 1'b0, 1'b0, 1'b1));
        send_sample(sample(1'b1, 1'b1, 1'b1, 1'b0));
        send_sample(sample(1'b0, 1'b0, 1'b0, 1'b1));
    endtask

    task automatic test_plug_and_trip();
        flow_mode = FLOW_FREE;
        wait_drained();
        put_reg(sps_pkg::CFG_PLUG_DELAY, 16'd2);
        put_reg(sps_pkg::CFG_POT_ADDRESS, 16'h00FF);
        put_reg(sps_pkg::CFG_LIMIT_STEP, 16'd0);
        flush_regs();
        send_sample(sample(1'b0, 1'b1, 1'b0, 1'b0));
        send_sample(sample(1'b1, 1'b1, 1'b0, 1'b0));
        send_sample(sample(1'b1, 1'b1, 1'b0, 1'b1));
        send_sample(sample(1'b0, 1'b1, 1'b0, 1'b1));
        send_sample(sample(1'b1, 1'b1, 1'b0, 1'b1));
        // hold off until the slot has answered everything
        wait_drained();
        send_sample(sample(1'b0, 1'b0, 1'b1, 1'b0));
        send_sample(sample(1'b1, 1'b1, 1'b0, 1'b1));
        send_sample(sample(1'b0, 1'b0, 1'b0, 1'b0));
    endtask

    task automatic test_removal_cases();
        flow_mode = FLOW_RECV_STALLS;
        wait_drained();
        put_reg(sps_pkg::CFG_PLUG_DELAY, 16'd5);
        put_reg(sps_pkg::CFG_LIMIT_STEP, 16'd31);
        put_reg(sps_pkg::CFG_POT_ADDRESS, 16'd0);
        flush_regs();
        send_sample(sample(1'b1, 1'b1, 1'b0, 1'b0));
        send_sample(sample(1'b1, 1'b0, 1'b0, 1'b0));
        wait_drained();
        put_reg(sps_pkg::CFG_PLUG_DELAY, 16'd0);
        flush_regs();
        send_sample(sample(1'b0, 1'b1, 1'b0, 1'b0));
        send_sample(sample(1'b0, 1'b0, 1'b0, 1'b0));
        send_sample(sample(1'b0, 1'b0, 1'b0, 1'b1));
        send_sample(sample(1'b0, 1'b0, 1'b0, 1'b0));
        send_sample(sample(1'b1, 1'b0, 1'b1, 1'b1));
    endtask

    task automatic test_random_service();
        int          p;
        int          n;
        logic [15:0] plug;
        logic [15:0] start;
        for (p = 0; p < 8; p++) begin
            wait_drained();
            flow_mode = p % 4;
            case ($urandom_range(0, 5))
                0:       plug = 16'd0;
                1:       plug = 16'hFFFF;
                2:       plug = 16'($urandom_range(5, 24));
                default: plug = 16'($urandom_range(1, 4));
            endcase
            case (p)
                1:       start = 16'd0;
                2:       start = 16'hFFFF;
                default: start = 16'($urandom);
            endcase
            put_reg(sps_pkg::CFG_START_DELAY, start);
            put_reg(sps_pkg::CFG_PLUG_DELAY, plug);
            put_reg(sps_pkg::CFG_LIMIT_STEP, (p == 3) ? 16'd20 : 16'($urandom));
            put_reg(sps_pkg::CFG_POT_ADDRESS, 16'($urandom));
            flush_regs();
            for (n = 0; n < 240; n++) begin
                send_sample(random_sample());
            end
        end
    endtask

    initial begin
        start_delay_r = 16'd10;
        plug_delay_r  = 16'd500;
        limit_step_r  = 5'd20;
        pot_address_r = 8'd88;
        slot_phase    = sps_pkg::ST_START;
        ticks_left    = start_delay_r;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        test_start_sequence();
        test_plug_and_trip();
        test_removal_cases();
        test_random_service();
        wait_drained();
        repeat (4) @(posedge aclk);
        $display("covered %0d service samples over four flow modes, %0d results checked",
                 sample_count, result_count);
        $display("%0d bus writes and %0d fuse trips predicted", write_count, trip_count);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #(5_000_000);
        $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/sps_pkg.sv
rtl/sps_cfg.sv
rtl/sps_fsm.sv
rtl/slot_power_sequencer.sv
bench/tb_slot_power_sequencer.sv
